// File: hw/rtl/mfrza_pkg.sv
`timescale 1ns / 1ps

package mfrza_pkg;

	localparam int unsigned DATA_W = 12;

	typedef logic [DATA_W-1:0] dist_t;

	typedef enum logic [1:0] {
		ZONE_NONE   = 2'd0,
		ZONE_RED    = 2'd1,
		ZONE_YELLOW = 2'd2,
		ZONE_GREEN  = 2'd3
	} zone_t;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RED_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_YELLOW_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID        = 2'd2;

	// 7 cm, 14 cm and 100 cm with 4 fraction bits
	localparam dist_t RED_THRESHOLD_RST    = 12'd112;
	localparam dist_t YELLOW_THRESHOLD_RST = 12'd224;
	localparam dist_t MAX_VALID_RST        = 12'd1600;

endpackage

// File: hw/rtl/median_filtered_range_zone_alarm.sv
`timescale 1ns / 1ps

// Median-filtered range zone alarm.
// Input stream (s_axis_*): one distance sample per item, cm with 4 fraction
// bits in tdata[11:0]. A sample above max_valid counts as zero; a nonzero
// sample overwrites the oldest entry of a WINDOW_LEN-deep ring.
// Output stream (m_axis_*): one item per input item, carrying the median of
// the ring after the update, the zone of the screened sample and the alarm.
// Config port: cfg_we/cfg_index/cfg_data write red_threshold (0),
// yellow_threshold (1) and max_valid (2); other indexes are ignored. Write
// only while the block is idle.
// Path: input register, then the ring update, rank-select median and zone
// compare feed the output register. Throughput: one item per cycle while
// the output is not stalled; the ring update and median network complete
// within the single stage between the two registers.
// Reset: ring cleared to zero, pointer to slot 0, thresholds to 7 cm, 14 cm
// and 100 cm. Early medians therefore include zeros.
// Stall: when m_axis_tready is low the output register holds its item; the
// input register takes one more item if it is empty, then s_axis_tready drops.
module median_filtered_range_zone_alarm #(
	parameter int unsigned WINDOW_LEN = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [11:0] sample, [15:12] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [11:0] median_out, [13:12] zone, [14] alarm, [15] zero
	input  logic        cfg_we,
	input  logic [mfrza_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfrza_pkg::DATA_W-1:0]    cfg_data
);

	localparam int unsigned PTR_W = $clog2(WINDOW_LEN);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

	mfrza_pkg::dist_t red_thr_q;
	mfrza_pkg::dist_t yellow_thr_q;
	mfrza_pkg::dist_t max_valid_q;

	logic             valid_s1;
	mfrza_pkg::dist_t sample_s1;

	logic [WINDOW_LEN-1:0][mfrza_pkg::DATA_W-1:0] window_q;
	logic [WINDOW_LEN-1:0][mfrza_pkg::DATA_W-1:0] window_d;
	logic [PTR_W-1:0]                             wr_ptr_q;

	logic             out_valid_q;
	logic [15:0]      out_data_q;

	logic             advance;
	mfrza_pkg::dist_t screened;
	logic             nonzero;
	mfrza_pkg::dist_t median;
	mfrza_pkg::zone_t zone;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_thr_q    <= mfrza_pkg::RED_THRESHOLD_RST;
			yellow_thr_q <= mfrza_pkg::YELLOW_THRESHOLD_RST;
			max_valid_q  <= mfrza_pkg::MAX_VALID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mfrza_pkg::REG_RED_THRESHOLD:    red_thr_q    <= cfg_data;
				mfrza_pkg::REG_YELLOW_THRESHOLD: yellow_thr_q <= cfg_data;
				mfrza_pkg::REG_MAX_VALID:        max_valid_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1 <= s_axis_tdata[mfrza_pkg::DATA_W-1:0];
		end
	end

	// screen, ring update, zone
	assign screened = (sample_s1 > max_valid_q) ? '0 : sample_s1;
	assign nonzero  = (screened != '0);

	always_comb begin
		window_d = window_q;
		if (nonzero) begin
			window_d[wr_ptr_q] = screened;
		end
	end

	always_comb begin
		if (!nonzero) begin
			zone = mfrza_pkg::ZONE_NONE;
		end else if (screened <= red_thr_q) begin
			zone = mfrza_pkg::ZONE_RED;
		end else if (screened <= yellow_thr_q) begin
			zone = mfrza_pkg::ZONE_YELLOW;
		end else begin
			zone = mfrza_pkg::ZONE_GREEN;
		end
	end

	mfrza_median #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_median (
		.entries(window_d),
		.median (median)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			wr_ptr_q <= '0;
		end else if (advance && nonzero) begin
			window_q <= window_d;
			wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {1'b0, (zone == mfrza_pkg::ZONE_RED), zone, median};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: hw/rtl/mfrza_median.sv
`timescale 1ns / 1ps

// Rank-select median: each entry counts the entries that sort ahead of it
// (smaller, or equal with a lower slot), so every entry has a unique rank.
module mfrza_median #(
	parameter int unsigned WINDOW_LEN = 7
) (
	input  logic [WINDOW_LEN-1:0][mfrza_pkg::DATA_W-1:0] entries,
	output mfrza_pkg::dist_t                              median
);

	localparam int unsigned RANK_W = $clog2(WINDOW_LEN);
	localparam logic [RANK_W-1:0] MID = RANK_W'(WINDOW_LEN / 2);

	logic [WINDOW_LEN-1:0][RANK_W-1:0] rank;
	logic [WINDOW_LEN-1:0]             is_mid;

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_rank
		always_comb begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW_LEN; j++) begin
				if (j != i) begin
					if ((entries[j] < entries[i]) ||
					    ((entries[j] == entries[i]) && (j < i))) begin
						rank[i] = rank[i] + RANK_W'(1);
					end
				end
			end
		end
		assign is_mid[i] = (rank[i] == MID);
	end

	// exactly one entry holds the middle rank
	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			median = median | (entries[i] & {mfrza_pkg::DATA_W{is_mid[i]}});
		end
	end

endmodule

// File: tb/tb_median_filtered_range_zone_alarm.sv
`timescale 1ns / 1ps

module tb_median_filtered_range_zone_alarm;

	localparam int unsigned WIN = 7;
	localparam int RAND_PHASES = 9;
	localparam int PHASE_ITEMS = 150;
	// index with no register behind it
	localparam logic [mfrza_pkg::CFG_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;

	typedef struct {
		mfrza_pkg::dist_t median;
		mfrza_pkg::zone_t zone;
		logic             alarm;
	} alarm_reading_t;

	// Mirrors the ring, pointer and thresholds; one expected reading per sample.
	class range_alarm_tracker;
		mfrza_pkg::dist_t red_thr;
		mfrza_pkg::dist_t yellow_thr;
		mfrza_pkg::dist_t max_dist;
		mfrza_pkg::dist_t ring [WIN];
		int unsigned wr_ptr;
		alarm_reading_t awaited_readings [$];
		int errors;
		int samples;
		int screened;
		int zone_hits [4];

		function new();
			red_thr = mfrza_pkg::RED_THRESHOLD_RST;
			yellow_thr = mfrza_pkg::YELLOW_THRESHOLD_RST;
			max_dist = mfrza_pkg::MAX_VALID_RST;
			foreach (ring[i]) ring[i] = '0;
			wr_ptr = 0;
			errors = 0;
			samples = 0;
			screened = 0;
			foreach (zone_hits[i]) zone_hits[i] = 0;
		endfunction

		function void set_reg(logic [mfrza_pkg::CFG_IDX_W-1:0] idx, mfrza_pkg::dist_t v);
			case (idx)
				mfrza_pkg::REG_RED_THRESHOLD: red_thr = v;
				mfrza_pkg::REG_YELLOW_THRESHOLD: yellow_thr = v;
				mfrza_pkg::REG_MAX_VALID: max_dist = v;
				default: ;
			endcase
		endfunction

		function mfrza_pkg::dist_t ring_median();
			int lt;
			int le;
			for (int i = 0; i < WIN; i++) begin
				lt = 0;
				le = 0;
				for (int j = 0; j < WIN; j++) begin
					if (ring[j] < ring[i]) lt++;
					if (ring[j] <= ring[i]) le++;
				end
				if (lt <= WIN / 2 && WIN / 2 < le) return ring[i];
			end
			return '0;
		endfunction

		function void take_sample(mfrza_pkg::dist_t raw);
			mfrza_pkg::dist_t d;
			alarm_reading_t r;
			d = raw;
			if (d > max_dist) begin
				d = '0;
				screened++;
			end
			if (d != '0) begin
				ring[wr_ptr] = d;
				wr_ptr = (wr_ptr == WIN - 1) ? 0 : wr_ptr + 1;
			end
			if (d == '0) r.zone = mfrza_pkg::ZONE_NONE;
			else if (d <= red_thr) r.zone = mfrza_pkg::ZONE_RED;
			else if (d <= yellow_thr) r.zone = mfrza_pkg::ZONE_YELLOW;
			else r.zone = mfrza_pkg::ZONE_GREEN;
			r.alarm = (r.zone == mfrza_pkg::ZONE_RED);
			r.median = ring_median();
			zone_hits[r.zone]++;
			samples++;
			awaited_readings.push_back(r);
		endfunction

		function void match_reading(logic [15:0] word);
			alarm_reading_t r;
			if (awaited_readings.size() == 0) begin
				$error("median_out: item with no sample pending, actual %0d", word[11:0]);
				errors++;
				return;
			end
			r = awaited_readings.pop_front();
			if (word[11:0] !== r.median) begin
				$error("median_out: expected %0d actual %0d", r.median, word[11:0]);
				errors++;
			end
			if (word[13:12] !== r.zone) begin
				$error("zone: expected %0d actual %0d", r.zone, word[13:12]);
				errors++;
			end
			if (word[14] !== r.alarm) begin
				$error("alarm: expected %0d actual %0d", r.alarm, word[14]);
				errors++;
			end
			if (word[15] !== 1'b0) begin
				$error("pad: expected 0 actual %0d", word[15]);
				errors++;
			end
		endfunction

		function int outstanding();
			return awaited_readings.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // [11:0] sample, [15:12] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;  // [11:0] median_out, [13:12] zone, [14] alarm, [15] zero
	logic        cfg_we;
	logic [mfrza_pkg::CFG_IDX_W-1:0] cfg_index;
	mfrza_pkg::dist_t cfg_data;

	range_alarm_tracker tracker = new();
	int rx_hold = 0;
	bit rx_gaps = 1'b1;
	bit tx_gaps = 1'b1;
	int settings_used = 0;

	median_filtered_range_zone_alarm #(
		.WINDOW_LEN(WIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** median_filtered_range_zone_alarm: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) tracker.take_sample(s_axis_tdata[11:0]);
			if (m_axis_tvalid && m_axis_tready) tracker.match_reading(m_axis_tdata);
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			if (rx_hold != 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic push_sample(input mfrza_pkg::dist_t v);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, v};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mfrza_pkg::CFG_IDX_W-1:0] idx,
		input mfrza_pkg::dist_t v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		tracker.set_reg(idx, v);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_thresholds(input mfrza_pkg::dist_t r, input mfrza_pkg::dist_t y,
		input mfrza_pkg::dist_t m);
		write_reg(mfrza_pkg::REG_RED_THRESHOLD, r);
		write_reg(mfrza_pkg::REG_YELLOW_THRESHOLD, y);
		write_reg(mfrza_pkg::REG_MAX_VALID, m);
		settings_used++;
	endtask

	// mostly in-range distances, with zeros, screened-out values and threshold edges
	function automatic mfrza_pkg::dist_t pick_sample();
		int m;
		int t;
		m = tracker.max_dist;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return (m == 4095) ? mfrza_pkg::dist_t'($urandom_range(0, 4095)) :
				mfrza_pkg::dist_t'($urandom_range(m + 1, 4095));
			2: return mfrza_pkg::dist_t'($urandom_range(0, 4095));
			3: begin
				case ($urandom_range(0, 2))
					0: t = tracker.red_thr;
					1: t = tracker.yellow_thr;
					default: t = m;
				endcase
				t = t - 1 + $urandom_range(0, 2);
				if (t < 0) t = 0;
				if (t > 4095) t = 4095;
				return mfrza_pkg::dist_t'(t);
			end
			default: return (m == 0) ? mfrza_pkg::dist_t'(0) :
				mfrza_pkg::dist_t'($urandom_range(1, m));
		endcase
	endfunction

	task automatic run_phase(input int n_items, input int pause_at);
		for (int k = 0; k < n_items; k++) begin
			if (k == pause_at) drain();
			if (tx_gaps && $urandom_range(0, 4) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			push_sample(pick_sample());
		end
	endtask

	initial begin
		mfrza_pkg::dist_t opening [14] = '{12'd0, 12'd4095, 12'd1601, 12'd1600, 12'd112,
			12'd113, 12'd224, 12'd225, 12'd1, 12'd56, 12'd0, 12'd300, 12'd2047, 12'd800};
		int r;
		int y;
		int m;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds; ring still holds zeros for the first medians
		foreach (opening[i]) push_sample(opening[i]);
		drain();

		// red never fires, everything valid is green
		load_thresholds(12'd0, 12'd0, 12'd4095);
		push_sample(12'd4095);
		push_sample(12'd1);
		push_sample(12'd0);
		drain();

		// everything red
		load_thresholds(12'd4095, 12'd4095, 12'd4095);
		push_sample(12'd4095);
		push_sample(12'd2730);
		drain();

		// yellow bound below red bound
		load_thresholds(12'd2000, 12'd1000, 12'd3000);
		push_sample(12'd1500);
		push_sample(12'd2001);
		push_sample(12'd900);
		push_sample(12'd3001);
		drain();

		// every sample screened out, then a write to the unused index
		write_reg(mfrza_pkg::REG_MAX_VALID, 12'd0);
		push_sample(12'd5);
		drain();
		write_reg(REG_UNUSED_IDX, 12'hA5A);
		push_sample(12'd1);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if ($urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, 4095);
				y = $urandom_range(0, 4095);
				m = $urandom_range(0, 4095);
			end else begin
				r = $urandom_range(0, 800);
				y = r + $urandom_range(0, 800);
				m = $urandom_range(y, 4095);
			end
			load_thresholds(mfrza_pkg::dist_t'(r), mfrza_pkg::dist_t'(y),
				mfrza_pkg::dist_t'(m));
			if (p == RAND_PHASES - 1) begin
				rx_gaps = 1'b0;
				tx_gaps = 1'b0;
			end
			// long receiver hold so the input side backs up
			if (p == 2) rx_hold = 60;
			run_phase(PHASE_ITEMS, (p == 4) ? PHASE_ITEMS / 2 : -1);
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Covered %0d samples (%0d screened out) over %0d threshold settings;",
			tracker.samples, tracker.screened, settings_used);
		$display("zones seen: none %0d, red %0d, yellow %0d, green %0d",
			tracker.zone_hits[mfrza_pkg::ZONE_NONE], tracker.zone_hits[mfrza_pkg::ZONE_RED],
			tracker.zone_hits[mfrza_pkg::ZONE_YELLOW],
			tracker.zone_hits[mfrza_pkg::ZONE_GREEN]);
		if (tracker.errors == 0 && tracker.outstanding() == 0) begin
			$display("** median_filtered_range_zone_alarm: PASSED **");
		end else begin
			$display("** median_filtered_range_zone_alarm: FAILED **");
		end
		$finish;
	end

endmodule
